// ===== rtl/sha512bc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha512bc_pkg
// Shared types, constants and SHA-512 helper functions of the compression unit.
// ----------------------------------------------------------------------------
package sha512bc_pkg;

	localparam logic [3:0] WORDS_LAST   = 4'd15;
	localparam logic [6:0] ROUND_LAST   = 7'd79;
	localparam logic [3:0] DIGEST_WORDS = 4'd8;
	localparam logic [2:0] DIGEST_LAST  = 3'd7;

	localparam logic [63:0] SHA_IV [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_INIT,
		ST_ROUND,
		ST_FINAL
	} sbc_state_t;

	typedef struct packed {
		logic       load_word;
		logic       reload_iv;
		logic       init;
		logic       round;
		logic       finish;
		logic       out_shift;
		logic [6:0] k_idx;
	} sbc_cmd_t;

	function automatic logic [63:0] big_sigma0(input logic [63:0] x);
		big_sigma0 = {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
	endfunction

	function automatic logic [63:0] big_sigma1(input logic [63:0] x);
		big_sigma1 = {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
	endfunction

	function automatic logic [63:0] small_sigma0(input logic [63:0] x);
		small_sigma0 = {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ (x >> 7);
	endfunction

	function automatic logic [63:0] small_sigma1(input logic [63:0] x);
		small_sigma1 = {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ (x >> 6);
	endfunction

	function automatic logic [63:0] round_const(input logic [6:0] idx);
		case (idx)
			7'd0:  round_const = 64'h428a2f98d728ae22;
			7'd1:  round_const = 64'h7137449123ef65cd;
			7'd2:  round_const = 64'hb5c0fbcfec4d3b2f;
			7'd3:  round_const = 64'he9b5dba58189dbbc;
			7'd4:  round_const = 64'h3956c25bf348b538;
			7'd5:  round_const = 64'h59f111f1b605d019;
			7'd6:  round_const = 64'h923f82a4af194f9b;
			7'd7:  round_const = 64'hab1c5ed5da6d8118;
			7'd8:  round_const = 64'hd807aa98a3030242;
			7'd9:  round_const = 64'h12835b0145706fbe;
			7'd10: round_const = 64'h243185be4ee4b28c;
			7'd11: round_const = 64'h550c7dc3d5ffb4e2;
			7'd12: round_const = 64'h72be5d74f27b896f;
			7'd13: round_const = 64'h80deb1fe3b1696b1;
			7'd14: round_const = 64'h9bdc06a725c71235;
			7'd15: round_const = 64'hc19bf174cf692694;
			7'd16: round_const = 64'he49b69c19ef14ad2;
			7'd17: round_const = 64'hefbe4786384f25e3;
			7'd18: round_const = 64'h0fc19dc68b8cd5b5;
			7'd19: round_const = 64'h240ca1cc77ac9c65;
			7'd20: round_const = 64'h2de92c6f592b0275;
			7'd21: round_const = 64'h4a7484aa6ea6e483;
			7'd22: round_const = 64'h5cb0a9dcbd41fbd4;
			7'd23: round_const = 64'h76f988da831153b5;
			7'd24: round_const = 64'h983e5152ee66dfab;
			7'd25: round_const = 64'ha831c66d2db43210;
			7'd26: round_const = 64'hb00327c898fb213f;
			7'd27: round_const = 64'hbf597fc7beef0ee4;
			7'd28: round_const = 64'hc6e00bf33da88fc2;
			7'd29: round_const = 64'hd5a79147930aa725;
			7'd30: round_const = 64'h06ca6351e003826f;
			7'd31: round_const = 64'h142929670a0e6e70;
			7'd32: round_const = 64'h27b70a8546d22ffc;
			7'd33: round_const = 64'h2e1b21385c26c926;
			7'd34: round_const = 64'h4d2c6dfc5ac42aed;
			7'd35: round_const = 64'h53380d139d95b3df;
			7'd36: round_const = 64'h650a73548baf63de;
			7'd37: round_const = 64'h766a0abb3c77b2a8;
			7'd38: round_const = 64'h81c2c92e47edaee6;
			7'd39: round_const = 64'h92722c851482353b;
			7'd40: round_const = 64'ha2bfe8a14cf10364;
			7'd41: round_const = 64'ha81a664bbc423001;
			7'd42: round_const = 64'hc24b8b70d0f89791;
			7'd43: round_const = 64'hc76c51a30654be30;
			7'd44: round_const = 64'hd192e819d6ef5218;
			7'd45: round_const = 64'hd69906245565a910;
			7'd46: round_const = 64'hf40e35855771202a;
			7'd47: round_const = 64'h106aa07032bbd1b8;
			7'd48: round_const = 64'h19a4c116b8d2d0c8;
			7'd49: round_const = 64'h1e376c085141ab53;
			7'd50: round_const = 64'h2748774cdf8eeb99;
			7'd51: round_const = 64'h34b0bcb5e19b48a8;
			7'd52: round_const = 64'h391c0cb3c5c95a63;
			7'd53: round_const = 64'h4ed8aa4ae3418acb;
			7'd54: round_const = 64'h5b9cca4f7763e373;
			7'd55: round_const = 64'h682e6ff3d6b2b8a3;
			7'd56: round_const = 64'h748f82ee5defb2fc;
			7'd57: round_const = 64'h78a5636f43172f60;
			7'd58: round_const = 64'h84c87814a1f0ab72;
			7'd59: round_const = 64'h8cc702081a6439ec;
			7'd60: round_const = 64'h90befffa23631e28;
			7'd61: round_const = 64'ha4506cebde82bde9;
			7'd62: round_const = 64'hbef9a3f7b2c67915;
			7'd63: round_const = 64'hc67178f2e372532b;
			7'd64: round_const = 64'hca273eceea26619c;
			7'd65: round_const = 64'hd186b8c721c0c207;
			7'd66: round_const = 64'heada7dd6cde0eb1e;
			7'd67: round_const = 64'hf57d4f7fee6ed178;
			7'd68: round_const = 64'h06f067aa72176fba;
			7'd69: round_const = 64'h0a637dc5a2c898a6;
			7'd70: round_const = 64'h113f9804bef90dae;
			7'd71: round_const = 64'h1b710b35131c471b;
			7'd72: round_const = 64'h28db77f523047d84;
			7'd73: round_const = 64'h32caab7b40c72493;
			7'd74: round_const = 64'h3c9ebe0a15c9bebc;
			7'd75: round_const = 64'h431d67c49c100d4c;
			7'd76: round_const = 64'h4cc5d4becb3e42b6;
			7'd77: round_const = 64'h597f299cfc657e2a;
			7'd78: round_const = 64'h5fcb6fab3ad6faec;
			7'd79: round_const = 64'h6c44198c4a475817;
			default: round_const = 64'h0;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sha512bc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha512bc_ctrl
// Sequencer for word loading, the eighty rounds, the chaining update and the
// delivery of the eight digest words.
// ----------------------------------------------------------------------------
module sha512bc_ctrl
	import sha512bc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       start_message,
	output logic            in_stall,
	input  wire logic       out_stall,
	output logic            out_valid,
	output logic [2:0]      word_index,
	output logic            last_word,
	output sbc_cmd_t        cmd
);

	sbc_state_t state_q;
	sbc_state_t state_next;
	logic [3:0] word_cnt_q;
	logic [6:0] round_q;
	logic [3:0] out_cnt_q;
	logic [2:0] out_idx_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_stall   = (state_q != ST_LOAD);
	assign in_xfer    = in_valid && !in_stall;
	assign out_valid  = (out_cnt_q != 4'd0);
	assign out_xfer   = out_valid && !out_stall;
	assign word_index = out_idx_q;
	assign last_word  = (out_idx_q == DIGEST_LAST);

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_xfer && (word_cnt_q == WORDS_LAST)) begin
					state_next = ST_INIT;
				end
			end
			ST_INIT: begin
				state_next = ST_ROUND;
			end
			ST_ROUND: begin
				if (round_q == ROUND_LAST) begin
					state_next = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (out_cnt_q == 4'd0) begin
					state_next = ST_LOAD;
				end
			end
			default: begin
				state_next = ST_LOAD;
			end
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.out_shift = out_xfer;
		case (state_q)
			ST_LOAD: begin
				cmd.load_word = in_xfer;
				cmd.reload_iv = in_xfer && start_message && (word_cnt_q == 4'd0);
			end
			ST_INIT: begin
				cmd.init  = 1'b1;
				cmd.k_idx = 7'd0;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				cmd.k_idx = round_q + 7'd1;
			end
			ST_FINAL: begin
				cmd.finish = (out_cnt_q == 4'd0);
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			word_cnt_q <= 4'd0;
			round_q    <= 7'd0;
			out_cnt_q  <= 4'd0;
			out_idx_q  <= 3'd0;
		end else begin
			state_q <= state_next;
			if (in_xfer) begin
				word_cnt_q <= word_cnt_q + 4'd1;
			end
			if (state_q == ST_INIT) begin
				round_q <= 7'd0;
			end else if (state_q == ST_ROUND) begin
				round_q <= round_q + 7'd1;
			end
			if (cmd.finish) begin
				out_cnt_q <= DIGEST_WORDS;
				out_idx_q <= 3'd0;
			end else if (out_xfer) begin
				out_cnt_q <= out_cnt_q - 4'd1;
				out_idx_q <= out_idx_q + 3'd1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_last_word_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (word_cnt_q == WORDS_LAST) |=> state_q == ST_INIT)
		else $error("sixteenth word did not start compression");
	a_rounds_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) && (round_q == ROUND_LAST) |=> state_q == ST_FINAL)
		else $error("round count overran");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !out_valid)
		else $error("digest buffer overwritten while results pending");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= DIGEST_WORDS)
		else $error("output count out of range");
	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && last_word |=> !out_valid)
		else $error("results remain after the final digest word");
`endif

endmodule
`default_nettype wire

// ===== rtl/sha512bc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha512bc_dp
// Schedule window, working variables, round logic, chaining value and the
// digest output buffer.
// ----------------------------------------------------------------------------
module sha512bc_dp
	import sha512bc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire sbc_cmd_t    cmd,
	input  wire logic [63:0] message_word,
	output logic      [63:0] digest_word
);

	logic [63:0] win_q [16];
	logic [63:0] wv_q  [8];
	logic [63:0] cv_q  [8];
	logic [63:0] ob_q  [8];
	logic [63:0] pre_q;
	logic [63:0] sched_new;
	logic [63:0] ch;
	logic [63:0] maj;
	logic [63:0] t1;
	logic [63:0] t2;
	logic [63:0] kconst;

	assign kconst    = round_const(cmd.k_idx);
	assign sched_new = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
	assign ch        = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
	assign maj       = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
	assign t1        = pre_q + big_sigma1(wv_q[4]) + ch;
	assign t2        = big_sigma0(wv_q[0]) + maj;
	assign digest_word = ob_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 8; j++) begin
				cv_q[j] <= SHA_IV[j];
			end
		end else if (cmd.reload_iv) begin
			for (int j = 0; j < 8; j++) begin
				cv_q[j] <= SHA_IV[j];
			end
		end else if (cmd.finish) begin
			for (int j = 0; j < 8; j++) begin
				cv_q[j] <= cv_q[j] + wv_q[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_word || cmd.round) begin
			for (int j = 0; j < 15; j++) begin
				win_q[j] <= win_q[j + 1];
			end
			win_q[15] <= cmd.load_word ? message_word : sched_new;
		end
		if (cmd.init) begin
			for (int j = 0; j < 8; j++) begin
				wv_q[j] <= cv_q[j];
			end
			pre_q <= kconst + win_q[0] + cv_q[7];
		end else if (cmd.round) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
			pre_q   <= kconst + win_q[1] + wv_q[6];
		end
		if (cmd.finish) begin
			for (int j = 0; j < 8; j++) begin
				ob_q[j] <= cv_q[j] + wv_q[j];
			end
		end else if (cmd.out_shift) begin
			for (int j = 0; j < 7; j++) begin
				ob_q[j] <= ob_q[j + 1];
			end
			ob_q[7] <= ob_q[7];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sha512_block_compress_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha512_block_compress_unit
// SHA-512 compression of 1024-bit blocks fed as sixteen 64-bit words.
// ----------------------------------------------------------------------------
// The input channel takes one big-endian message word per transfer; a set
// start_message on the first word of a block reloads the initial hash value.
// Words are taken one per cycle while the unit is loading. After the sixteenth
// transfer the input stalls through a setup state, the eighty rounds at one
// round per cycle and the chaining update. The eight chaining words then
// appear on the output channel, word 0 first, with word_index on each and
// last_word on the eighth. The input takes no new block until the chaining
// update of the previous block is done.
// The digest words sit in their own buffer, so the next block loads and
// compresses while the receiver stalls; only the chaining update waits until
// all eight words of the previous block have been transferred.
// Reset returns the chaining value to the initial hash value, clears the
// word count and drops any pending results.
// ----------------------------------------------------------------------------
module sha512_block_compress_unit
	import sha512bc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] message_word,
	input  wire logic        start_message,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [63:0] digest_word,
	output logic      [2:0]  word_index,
	output logic             last_word
);

	sbc_cmd_t cmd;

	sha512bc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.start_message (start_message),
		.in_stall      (in_stall),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.word_index    (word_index),
		.last_word     (last_word),
		.cmd           (cmd)
	);

	sha512bc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.message_word (message_word),
		.digest_word  (digest_word)
	);

endmodule
`default_nettype wire

// ===== verif/tb_sha512_block_compress_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha512_block_compress_unit
// Self-checking testbench for the SHA-512 block compression unit.
// ----------------------------------------------------------------------------
// Message words are sent as sixteen-word blocks, and each accepted word is fed
// to a predictor that keeps its own chaining value and schedule and computes
// the eight digest words of every block. Each output transfer is checked
// against the oldest predicted word. The phases cover a first block hashed
// without a start flag, streaming with no idling, sender gaps, receiver
// stalls, both together, and a long receiver hold-off that backs up the unit.
// ----------------------------------------------------------------------------
module tb_sha512_block_compress_unit;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 120;
	localparam int HOLDOFF_CYCLES = 400;

	localparam logic [63:0] INIT_HASH [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam logic [63:0] ROUND_K [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	typedef struct packed {
		logic [63:0] word;
		logic [2:0]  index;
		logic        is_last;
	} digest_item_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] message_word;
	logic        start_message;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	logic [63:0]  hash_state [8];
	logic [63:0]  msg_window [16];
	logic [3:0]   words_held;
	digest_item_t digest_q [$];

	int error_count;
	int sender_idle_pct;
	int receiver_stall_pct;
	int holdoff_requests;
	int holdoff_served;
	int holdoff_left;
	int quiet_cycles;

	sha512_block_compress_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.message_word  (message_word),
		.start_message (start_message),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.digest_word   (digest_word),
		.word_index    (word_index),
		.last_word     (last_word)
	);

	initial begin
		clk = 1'b0;
	end

	always #6 clk = ~clk;

	function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	function automatic logic [63:0] sum_a(input logic [63:0] x);
		return ror64(x, 28) ^ ror64(x, 34) ^ ror64(x, 39);
	endfunction

	function automatic logic [63:0] sum_e(input logic [63:0] x);
		return ror64(x, 14) ^ ror64(x, 18) ^ ror64(x, 41);
	endfunction

	function automatic logic [63:0] sched_s0(input logic [63:0] x);
		return ror64(x, 1) ^ ror64(x, 8) ^ (x >> 7);
	endfunction

	function automatic logic [63:0] sched_s1(input logic [63:0] x);
		return ror64(x, 19) ^ ror64(x, 61) ^ (x >> 6);
	endfunction

	task automatic compress_block_into_state();
		logic [63:0]  v [8];
		logic [63:0]  w;
		logic [63:0]  t1;
		logic [63:0]  t2;
		digest_item_t item;
		int           j;
		int           t;
		for (j = 0; j < 8; j++)
			v[j] = hash_state[j];
		for (t = 0; t < 80; t++) begin
			if (t >= 16) begin
				w = sched_s1(msg_window[(t - 2) & 15]) + msg_window[(t - 7) & 15]
					+ sched_s0(msg_window[(t - 15) & 15]) + msg_window[t & 15];
				msg_window[t & 15] = w;
			end else begin
				w = msg_window[t];
			end
			t1 = v[7] + sum_e(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w;
			t2 = sum_a(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (j = 0; j < 8; j++) begin
			hash_state[j] = hash_state[j] + v[j];
			item.word     = hash_state[j];
			item.index    = j[2:0];
			item.is_last  = (j == 7);
			digest_q.push_back(item);
		end
	endtask

	task automatic absorb_word(input logic [63:0] w, input logic s);
		if (words_held == 4'd0 && s)
			hash_state = INIT_HASH;
		msg_window[words_held] = w;
		if (words_held == 4'd15)
			compress_block_into_state();
		words_held = words_held + 4'd1;
	endtask

	task automatic send_word(input logic [63:0] w, input logic s);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid      = 1'b0;
			message_word  = {$urandom, $urandom};
			start_message = 1'($urandom_range(1));
			@(negedge clk);
		end
		in_valid      = 1'b1;
		message_word  = w;
		start_message = s;
		do
			@(posedge clk);
		while (in_stall);
		absorb_word(w, s);
	endtask

	function automatic logic [63:0] random_word();
		case ($urandom_range(15))
			0:       return 64'h0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Messages of one to three blocks, a start flag on the first word, with
	// occasional stray start flags mid-block and messages that omit the flag.
	task automatic send_blocks(input int block_total);
		int  sent;
		int  msg_blocks;
		int  b;
		int  i;
		bit  flag_first;
		logic s;
		sent = 0;
		while (sent < block_total) begin
			msg_blocks = $urandom_range(3, 1);
			if (msg_blocks > block_total - sent)
				msg_blocks = block_total - sent;
			flag_first = ($urandom_range(9) != 0);
			for (b = 0; b < msg_blocks; b++) begin
				for (i = 0; i < 16; i++) begin
					if (i == 0)
						s = (b == 0) ? flag_first : ($urandom_range(7) == 0);
					else
						s = ($urandom_range(7) == 0);
					send_word(random_word(), s);
				end
			end
			sent = sent + msg_blocks;
		end
	endtask

	task automatic test_first_block_without_start();
		int i;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		send_word(64'h0, 1'b0);
		send_word('1, 1'b0);
		send_word(64'h8000_0000_0000_0000, 1'b0);
		send_word(64'h1, 1'b0);
		send_word(64'h5555_5555_5555_5555, 1'b0);
		// A start flag in the middle of a block must leave the chaining value alone.
		send_word(64'haaaa_aaaa_aaaa_aaaa, 1'b1);
		for (i = 6; i < 16; i++)
			send_word({$urandom, $urandom}, 1'b0);
	endtask

	task automatic test_streaming();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		send_blocks(6);
	endtask

	task automatic test_sender_gaps();
		sender_idle_pct    = 73;
		receiver_stall_pct = 0;
		send_blocks(4);
	endtask

	task automatic test_receiver_stalls();
		sender_idle_pct    = 0;
		receiver_stall_pct = 73;
		send_blocks(4);
	endtask

	task automatic test_both_idle();
		sender_idle_pct    = 38;
		receiver_stall_pct = 38;
		send_blocks(5);
	endtask

	task automatic test_receiver_holdoff();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		holdoff_requests   = holdoff_requests + 1;
		send_blocks(4);
	endtask

	always @(negedge clk) begin
		if (holdoff_requests != holdoff_served) begin
			holdoff_served = holdoff_requests;
			holdoff_left   = HOLDOFF_CYCLES;
		end
		if (holdoff_left > 0) begin
			holdoff_left = holdoff_left - 1;
			out_stall    = 1'b1;
		end else begin
			out_stall = ($urandom_range(99) < receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		digest_item_t exp_item;
		if (arst_n && out_valid && !out_stall) begin
			if (digest_q.size() == 0) begin
				$display("%0t: digest transfer with nothing expected: word %h index %0d last %b",
					$time, digest_word, word_index, last_word);
				error_count = error_count + 1;
			end else begin
				exp_item = digest_q.pop_front();
				if (digest_word !== exp_item.word) begin
					$display("%0t: digest_word mismatch: expected %h, actual %h",
						$time, exp_item.word, digest_word);
					error_count = error_count + 1;
				end
				if (word_index !== exp_item.index) begin
					$display("%0t: word_index mismatch: expected %0d, actual %0d",
						$time, exp_item.index, word_index);
					error_count = error_count + 1;
				end
				if (last_word !== exp_item.is_last) begin
					$display("%0t: last_word mismatch: expected %b, actual %b",
						$time, exp_item.is_last, last_word);
					error_count = error_count + 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n             = 1'b0;
		in_valid           = 1'b0;
		message_word       = 64'h0;
		start_message      = 1'b0;
		out_stall          = 1'b0;
		error_count        = 0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		holdoff_requests   = 0;
		holdoff_served     = 0;
		holdoff_left       = 0;
		quiet_cycles       = 0;
		hash_state         = INIT_HASH;
		words_held         = 4'd0;
		for (int k = 0; k < 16; k++)
			msg_window[k] = 64'h0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_first_block_without_start();
		test_streaming();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		test_receiver_holdoff();

		@(negedge clk);
		in_valid = 1'b0;
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/sha512bc_pkg.sv
rtl/sha512bc_ctrl.sv
rtl/sha512bc_dp.sv
rtl/sha512_block_compress_unit.sv
verif/tb_sha512_block_compress_unit.sv
